### src/saw_pkg.sv
// ----------------------------------------------------------------------------
// saw_pkg: shared types and constants for the stop-and-wait ARQ sender
// Header layout, request and result codes, and the header checksum.
// ----------------------------------------------------------------------------
package saw_pkg;

	localparam int FLAGS_W = 5;
	localparam int SEQ_W   = 16;
	localparam int LEN_W   = 11;
	localparam int CNT_W   = 16;
	localparam int CK_W    = 16;
	localparam int RETRY_W = 3;
	localparam int TICK_W  = 16;
	localparam int REQ_W   = 2;
	localparam int KIND_W  = 3;

	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 88;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = 2;
	localparam int OQ_CW    = 3;

	localparam logic [TICK_W-1:0]  TIMEOUT_RST     = 16'd2000;
	localparam logic [TICK_W-1:0]  TICK_MAX        = 16'hFFFF;
	localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 3'd5;
	localparam logic [RETRY_W-1:0] RETRY_MAX       = 3'd7;

	// flag bit positions
	localparam int F_SYN   = 0;
	localparam int F_ACK   = 1;
	localparam int F_FIN   = 2;
	localparam int F_START = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY   = 1'b1;

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK  = 2'd0,
		REQ_NEW   = 2'd1,
		REQ_REPLY = 2'd2
	} req_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_TX    = 3'd0,
		KIND_RETX  = 3'd1,
		KIND_ACKED = 3'd2,
		KIND_ABORT = 3'd3,
		KIND_BUSY  = 3'd4
	} kind_t;

	// packed MSB first, so flags land in the low bits of a word
	typedef struct packed {
		logic [CK_W-1:0]    checksum;
		logic [CNT_W-1:0]   count;
		logic [LEN_W-1:0]   length;
		logic [SEQ_W-1:0]   ack;
		logic [SEQ_W-1:0]   seq;
		logic [FLAGS_W-1:0] flags;
	} hdr_t;

	typedef struct packed {
		logic [REQ_W-1:0] req;
		hdr_t             hdr;
		logic [CK_W-1:0]  sum_inv;
	} item_t;

	typedef struct packed {
		kind_t              kind;
		logic               last;
		logic [RETRY_W-1:0] retries;
		hdr_t               hdr;
	} res_t;

	typedef struct packed {
		logic push0;
		logic push1;
		res_t res0;
		res_t res1;
	} oq_push_t;

	// Inverted ones'-complement sum of the 10 header bytes before the checksum,
	// little-endian byte order paired high/low. Folding the total twice matches
	// the running end-around carry.
	function automatic logic [CK_W-1:0] hdr_sum_inv(input hdr_t h);
		logic [18:0] total;
		logic [16:0] f1;
		logic [15:0] f2;
		total = {6'b000000, h.flags, 8'h00}
			+ {3'b000, h.seq[7:0], h.seq[15:8]}
			+ {3'b000, h.ack[7:0], h.ack[15:8]}
			+ {3'b000, h.length[7:0], 5'b00000, h.length[10:8]}
			+ {3'b000, h.count[7:0], h.count[15:8]};
		f1 = {1'b0, total[15:0]} + {14'd0, total[18:16]};
		f2 = f1[15:0] + {15'd0, f1[16]};
		return ~f2;
	endfunction

endpackage

### src/saw_ingress.sv
// ----------------------------------------------------------------------------
// saw_ingress: input register
// Captures a request word and its header checksum for the core.
// ----------------------------------------------------------------------------
module saw_ingress (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [saw_pkg::REQ_W-1:0]  in_req,
	input  saw_pkg::hdr_t              in_hdr,
	input  logic                       take,
	output logic                       valid_s1,
	output saw_pkg::item_t             item_s1
);

	logic           valid_s1_q;
	saw_pkg::item_t item_s1_q;

	assign in_ready = !valid_s1_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (in_ready) begin
			valid_s1_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1_q.req     <= in_req;
			item_s1_q.hdr     <= in_hdr;
			item_s1_q.sum_inv <= saw_pkg::hdr_sum_inv(in_hdr);
		end
	end

	assign valid_s1 = valid_s1_q;
	assign item_s1  = item_s1_q;

endmodule

### src/saw_core.sv
// ----------------------------------------------------------------------------
// saw_core: ARQ state and result generation
// Holds the outstanding header, timer and retry count; emits up to two words.
// ----------------------------------------------------------------------------
module saw_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [saw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [saw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            valid_s1,
	input  saw_pkg::item_t                  item_s1,
	input  logic                            room,
	output logic                            take,
	output saw_pkg::oq_push_t               push
);

	logic [saw_pkg::TICK_W-1:0]  timeout_q;
	logic [saw_pkg::RETRY_W-1:0] limit_q;

	logic                        waiting_q, waiting_n;
	saw_pkg::hdr_t               held_q, held_n;
	logic [saw_pkg::TICK_W-1:0]  elapsed_q, elapsed_n, elapsed_inc;
	logic [saw_pkg::RETRY_W-1:0] retry_q, retry_n;
	logic                        fire;
	logic                        control;
	logic [saw_pkg::SEQ_W-1:0]   want_ack;
	logic                        reply_ok;
	logic                        emit0, emit1;
	saw_pkg::kind_t              kind0;

	assign fire     = valid_s1 && room;
	assign take     = fire;
	assign control  = held_q.flags[saw_pkg::F_SYN] || held_q.flags[saw_pkg::F_FIN]
		|| held_q.flags[saw_pkg::F_START];
	assign want_ack = control ? held_q.seq + 16'd1 : held_q.seq;
	assign elapsed_inc = (elapsed_q == saw_pkg::TICK_MAX) ? elapsed_q : elapsed_q + 16'd1;

	assign reply_ok = item_s1.hdr.flags[saw_pkg::F_ACK]
		&& (item_s1.hdr.checksum == item_s1.sum_inv)
		&& (item_s1.hdr.ack == want_ack)
		&& !(held_q.flags[saw_pkg::F_SYN] && !item_s1.hdr.flags[saw_pkg::F_SYN]);

	always_comb begin
		waiting_n = waiting_q;
		held_n    = held_q;
		elapsed_n = elapsed_q;
		retry_n   = retry_q;
		emit0     = 1'b0;
		emit1     = 1'b0;
		kind0     = saw_pkg::KIND_TX;
		case (item_s1.req)
			saw_pkg::REQ_TICK: begin
				if (waiting_q) begin
					if (elapsed_inc > timeout_q) begin
						elapsed_n = '0;
						retry_n   = (retry_q == saw_pkg::RETRY_MAX) ? retry_q
							: retry_q + 3'd1;
						emit0     = 1'b1;
						kind0     = saw_pkg::KIND_RETX;
						if (!control && retry_n >= limit_q) begin
							// data packet out of retries: retransmit, then abort
							emit1     = 1'b1;
							waiting_n = 1'b0;
						end
					end else begin
						elapsed_n = elapsed_inc;
					end
				end
			end
			saw_pkg::REQ_NEW: begin
				emit0 = 1'b1;
				if (waiting_q) begin
					kind0 = saw_pkg::KIND_BUSY;
				end else begin
					kind0           = saw_pkg::KIND_TX;
					held_n          = item_s1.hdr;
					held_n.checksum = item_s1.sum_inv;
					elapsed_n       = '0;
					retry_n         = '0;
					waiting_n       = 1'b1;
				end
			end
			saw_pkg::REQ_REPLY: begin
				if (waiting_q && reply_ok) begin
					emit0     = 1'b1;
					kind0     = saw_pkg::KIND_ACKED;
					waiting_n = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		push.push0        = fire && emit0;
		push.push1        = fire && emit1;
		push.res0.kind    = kind0;
		push.res0.last    = !emit1;
		push.res0.retries = retry_n;
		push.res0.hdr     = held_n;
		push.res1.kind    = saw_pkg::KIND_ABORT;
		push.res1.last    = 1'b1;
		push.res1.retries = retry_n;
		push.res1.hdr     = held_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= saw_pkg::TIMEOUT_RST;
			limit_q   <= saw_pkg::RETRY_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				saw_pkg::CFG_TIMEOUT: timeout_q <= cfg_wdata;
				saw_pkg::CFG_RETRY:   limit_q   <= cfg_wdata[saw_pkg::RETRY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q <= 1'b0;
			held_q    <= '0;
			elapsed_q <= '0;
			retry_q   <= '0;
		end else if (fire) begin
			waiting_q <= waiting_n;
			held_q    <= held_n;
			elapsed_q <= elapsed_n;
			retry_q   <= retry_n;
		end
	end

	// an abort always ends the wait
	a_abort_idles: assert property (@(posedge clk) disable iff (!arst_n)
		push.push1 |=> !waiting_q)
		else $error("abort left the sender waiting");

	// a fresh transmit starts a clean timer and retry count
	a_tx_arms: assert property (@(posedge clk) disable iff (!arst_n)
		(push.push0 && push.res0.kind == saw_pkg::KIND_TX)
		|=> (waiting_q && retry_q == '0 && elapsed_q == '0))
		else $error("transmit did not arm the wait state");

endmodule

### src/saw_outq.sv
// ----------------------------------------------------------------------------
// saw_outq: result queue
// Four-entry queue, two writes and one read per cycle.
// ----------------------------------------------------------------------------
module saw_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  saw_pkg::oq_push_t push,
	output logic              room,
	output logic              out_valid,
	input  logic              out_ready,
	output saw_pkg::res_t     head
);

	saw_pkg::res_t              mem_q [saw_pkg::OQ_DEPTH];
	logic [saw_pkg::OQ_AW-1:0]  wptr_q, rptr_q;
	logic [saw_pkg::OQ_CW-1:0]  count_q;
	logic                       pop;

	assign out_valid = count_q != '0;
	assign pop       = out_valid && out_ready;
	assign room      = count_q <= saw_pkg::OQ_CW'(saw_pkg::OQ_DEPTH - 2);
	assign head      = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem_q[wptr_q] <= push.res0;
		end
		if (push.push1) begin
			mem_q[wptr_q + 2'd1] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + {1'b0, push.push0} + {1'b0, push.push1};
			rptr_q  <= rptr_q + {1'b0, pop};
			count_q <= count_q + {2'b00, push.push0} + {2'b00, push.push1}
				- {2'b00, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= saw_pkg::OQ_CW'(saw_pkg::OQ_DEPTH))
		else $error("result queue overflow");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.push0 |-> count_q <= saw_pkg::OQ_CW'(saw_pkg::OQ_DEPTH - 2))
		else $error("push into a queue without room for two words");

endmodule

### src/stop_and_wait_arq_sender.sv
// ----------------------------------------------------------------------------
// stop_and_wait_arq_sender: sender side of a stop-and-wait ARQ link
// Builds checksummed headers, tracks the outstanding one, retransmits on
// timeout and aborts data packets after the retry limit.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one request word per handshake. tuser selects tick, new
//   header or received reply; tdata carries the header fields.
//   Master stream: result words. tuser is the result kind (transmit,
//   retransmit, acknowledged, aborted, busy); tdata carries the stored
//   header, its checksum and the retry count; tlast marks the final word
//   a request produced (only a retry abort produces two).
//   Config: cfg_we writes timeout (index 0) or retry limit (index 1);
//   write only while no request is in flight.
// Path: a taken request is held in the input register, then the core's
//   state update writes its result words into the result queue, whose
//   head is shown on the master side.
// Throughput: one request per cycle while the result queue has room for
//   two more words; the queue drains one word per cycle.
// Reset: sender idle, header, timer and retry count cleared, timeout 2000,
//   retry limit 5, result queue empty.
// Stall: the four-entry result queue absorbs output stalls; once it cannot
//   take two more words the core holds and s_axis_tready drops.
// ----------------------------------------------------------------------------
module stop_and_wait_arq_sender (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// flags[4:0], seq[20:5], ack[36:21], length[47:37], count[63:48],
	// checksum[79:64]
	input  logic [saw_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// req_type[1:0]
	input  logic [saw_pkg::REQ_W-1:0]        s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// tx_flags[4:0], tx_seq[20:5], tx_ack[36:21], tx_length[47:37],
	// tx_count[63:48], tx_checksum[79:64], retries_used[82:80], zero pad
	output logic [saw_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// out_kind[2:0]
	output logic [saw_pkg::KIND_W-1:0]       m_axis_tuser,
	output logic                             m_axis_tlast,
	input  logic                             cfg_we,
	input  logic [saw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [saw_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	logic              valid_s1;
	saw_pkg::item_t    item_s1;
	logic              take;
	logic              room;
	saw_pkg::oq_push_t push;
	saw_pkg::res_t     head;

	// request capture and checksum
	saw_ingress u_ingress (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_req   (s_axis_tuser),
		.in_hdr   (saw_pkg::hdr_t'(s_axis_tdata)),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// protocol state; fires only when the queue has room for two words
	saw_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.room      (room),
		.take      (take),
		.push      (push)
	);

	saw_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.head      (head)
	);

	assign m_axis_tdata = {5'b00000, head.retries, head.hdr};
	assign m_axis_tuser = head.kind;
	assign m_axis_tlast = head.last;

endmodule
